// File: rtl/csh_pkg.sv
// shared types, constants and crc helper for the crc signature hash table
package csh_pkg;

   localparam int SIG_W   = 32;
   localparam int ENTRY_W = 12;
   localparam int STAT_W  = 2;

   localparam logic [SIG_W-1:0] CRC_POLY  = 32'hedb88320;
   localparam logic [SIG_W-1:0] SEED_ONE   = 32'h0000_0001;
   localparam logic [SIG_W-1:0] SEED_TWO   = 32'h0000_0002;
   localparam logic [SIG_W-1:0] SEED_THREE = 32'h0000_0004;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   localparam logic MODE_FIND = 1'b0;
   localparam logic MODE_ADD  = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [SIG_W-1:0] sig_one;
      logic [SIG_W-1:0] sig_two;
      logic [SIG_W-1:0] sig_three;
   } job_type;

   function automatic logic [SIG_W-1:0] crc_fold(input logic [SIG_W-1:0] crc,
                                                 input logic [7:0] data);
      logic [SIG_W-1:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/csh_ifs.sv
// request and response channel interfaces
interface csh_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] key_byte;
   logic       key_last;
   modport source (output valid, mode, key_byte, key_last, input ready);
   modport sink (input valid, mode, key_byte, key_last, output ready);
endinterface

interface csh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] entry_index;
   modport source (output valid, status, entry_index, input ready);
   modport sink (input valid, status, entry_index, output ready);
endinterface

// File: rtl/csh_ram.sv
// generic single write port ram with registered read
module csh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/csh_front.sv
// front end: folds key bytes into three crc signatures and emits a job on the last byte
module csh_front (
   input  logic            clock,
   input  logic            reset,
   csh_req_if.sink         req_chan,
   input  logic            clearing,
   input  logic            job_full,
   output logic            job_push,
   output csh_pkg::job_type job_data
);
   import csh_pkg::*;

   logic [SIG_W-1:0] sig_one_ff, sig_two_ff, sig_three_ff;
   logic [SIG_W-1:0] sig_one_in, sig_two_in, sig_three_in;
   logic [SIG_W-1:0] f_one, f_two, f_three;
   logic             accept;

   assign req_chan.ready = !clearing && !job_full;
   assign accept = req_chan.valid && req_chan.ready;

   assign f_one   = crc_fold(sig_one_ff, req_chan.key_byte);
   assign f_two   = crc_fold(sig_two_ff, req_chan.key_byte);
   assign f_three = crc_fold(sig_three_ff, req_chan.key_byte);

   always_comb begin
      sig_one_in   = sig_one_ff;
      sig_two_in   = sig_two_ff;
      sig_three_in = sig_three_ff;
      if (accept) begin
         if (req_chan.key_last) begin
            sig_one_in   = SEED_ONE;
            sig_two_in   = SEED_TWO;
            sig_three_in = SEED_THREE;
         end else begin
            sig_one_in   = f_one;
            sig_two_in   = f_two;
            sig_three_in = f_three;
         end
      end
   end

   assign job_push           = accept && req_chan.key_last;
   assign job_data.mode      = req_chan.mode;
   assign job_data.sig_one   = f_one;
   assign job_data.sig_two   = f_two;
   assign job_data.sig_three = f_three;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_one_ff   <= SEED_ONE;
         sig_two_ff   <= SEED_TWO;
         sig_three_ff <= SEED_THREE;
      end else begin
         sig_one_ff   <= sig_one_in;
         sig_two_ff   <= sig_two_in;
         sig_three_ff <= sig_three_in;
      end
   end
endmodule

// File: rtl/csh_queue.sv
// two entry job queue between front and back
module csh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  csh_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output csh_pkg::job_type pop_data
);
   import csh_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
endmodule

// File: rtl/csh_back.sv
// back end: clearing pass, head slot select, chain walk, insert and result register
module csh_back #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  csh_pkg::job_type job_data,
   output logic             job_pop,
   output logic             clearing,
   csh_rsp_if.source        rsp_chan
);
   import csh_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int HEADS    = TABLE_DEPTH / 4;
   localparam int HEAD_W   = $clog2(HEADS);
   localparam int OVF_SIZE = TABLE_DEPTH - HEADS;
   localparam int OVF_W    = $clog2(OVF_SIZE + 1);
   localparam int META_W   = 1 + IDX_W;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_APP  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   job_type           job_ff, job_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [OVF_W-1:0]  ovf_ff, ovf_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [ENTRY_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic [IDX_W:0]    fresh_wide;
   logic [IDX_W-1:0]  fresh;
   logic [ENTRY_W+IDX_W-1:0] res_wide;

   logic              meta_we;
   logic [IDX_W-1:0]  meta_addr;
   logic [META_W-1:0] meta_wd, meta_rd;
   logic              sig_we;
   logic [3*SIG_W-1:0] sig_rd;
   logic              used;
   logic [IDX_W-1:0]  link;
   logic              match;

   csh_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_addr), .wr_data(meta_wd),
      .rd_addr(idx_ff), .rd_data(meta_rd));

   csh_ram #(.WIDTH(3*SIG_W), .DEPTH(TABLE_DEPTH)) u_sig (
      .clock(clock), .wr_en(sig_we), .wr_addr(idx_ff),
      .wr_data({job_ff.sig_one, job_ff.sig_two, job_ff.sig_three}),
      .rd_addr(idx_ff), .rd_data(sig_rd));

   assign used  = meta_rd[META_W-1];
   assign link  = meta_rd[IDX_W-1:0];
   assign match = used && (sig_rd == {job_ff.sig_one, job_ff.sig_two, job_ff.sig_three});

   assign fresh_wide = (IDX_W+1)'(HEADS) + (IDX_W+1)'(ovf_ff);
   assign fresh      = fresh_wide[IDX_W-1:0];
   assign res_wide   = {{ENTRY_W{1'b0}}, res_idx_ff};

   assign clearing          = (state_ff == S_CLR);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_stat_ff;
   assign rsp_chan.entry_index = rsp_idx_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      res_stat_in  = res_stat_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_idx_in   = rsp_idx_ff;
      job_pop      = 1'b0;
      meta_we      = 1'b0;
      meta_addr    = idx_ff;
      meta_wd      = '0;
      sig_we       = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            meta_we   = 1'b1;
            meta_addr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               idx_in   = {{(IDX_W-HEAD_W){1'b0}}, job_data.sig_one[HEAD_W-1:0]};
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (job_ff.mode == MODE_FIND) begin
               if (match) begin
                  res_stat_in = ST_OK;
                  res_idx_in  = idx_ff;
                  state_in    = S_OUT;
               end else if (link == '0) begin
                  res_stat_in = ST_MISS;
                  res_idx_in  = '0;
                  state_in    = S_OUT;
               end else begin
                  idx_in   = link;
                  state_in = S_RD;
               end
            end else if (!used) begin
               meta_we     = 1'b1;
               meta_wd     = {1'b1, {IDX_W{1'b0}}};
               sig_we      = 1'b1;
               res_stat_in = ST_OK;
               res_idx_in  = idx_ff;
               state_in    = S_OUT;
            end else if (link != '0) begin
               idx_in   = link;
               state_in = S_RD;
            end else if (ovf_ff >= OVF_W'(OVF_SIZE)) begin
               res_stat_in = ST_FULL;
               res_idx_in  = '0;
               state_in    = S_OUT;
            end else begin
               meta_we  = 1'b1;
               meta_wd  = {1'b1, fresh};
               idx_in   = fresh;
               ovf_in   = ovf_ff + 1'b1;
               state_in = S_APP;
            end
         end
         S_APP: begin
            meta_we     = 1'b1;
            meta_wd     = {1'b1, {IDX_W{1'b0}}};
            sig_we      = 1'b1;
            res_stat_in = ST_OK;
            res_idx_in  = idx_ff;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_idx_in   = res_wide[ENTRY_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      res_stat_ff <= res_stat_in;
      res_idx_ff  <= res_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      ovf_ff <= OVF_W'(OVF_SIZE))
      else $error("overflow count beyond overflow area");
   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !job_pop)
      else $error("job taken during clearing pass");
   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && job_valid) |=> idx_ff < IDX_W'(HEADS))
      else $error("head slot outside head area");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("result not registered");
endmodule

// File: rtl/crc_signature_hash_table_core.sv
// top level of the crc signature hash table
// usage: key bytes enter on req_chan, one transaction per byte, with key_last
// marking the final byte and mode (0 find, 1 add) sampled with it. every final
// byte gives exactly one transaction on rsp_chan with status (0 found or
// inserted, 1 not found, 2 overflow area full) and entry_index.
// throughput: one key byte per cycle while the job queue has room. each key's
// table operation runs in the back end: S_IDLE takes the job and picks the
// head slot from the low bits of signature one (TABLE_DEPTH is a power of two),
// S_RD and S_CHK read and check each chain entry visited through the registered
// ram read, S_APP completes an append, and S_OUT loads the result register. a
// two entry queue lets the front keep folding bytes while the back end walks
// a chain. reset: a clearing pass zeroes the used bits and links of all
// TABLE_DEPTH entries; no byte is accepted until it completes.
// stall: the result register holds while rsp_chan.ready is low; the back end
// then waits and the front stalls once the queue is full.
module crc_signature_hash_table_core #(
   parameter int TABLE_DEPTH = 4096
) (
   input logic       clock,
   input logic       reset,
   csh_req_if.sink   req_chan,
   csh_rsp_if.source rsp_chan
);
   import csh_pkg::*;

   logic    clearing;
   logic    job_full, job_push, job_pop, job_valid;
   job_type job_in_data, job_out_data;

   csh_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .clearing(clearing),
      .job_full(job_full), .job_push(job_push), .job_data(job_in_data));

   csh_queue u_queue (
      .clock(clock), .reset(reset), .push(job_push), .push_data(job_in_data),
      .full(job_full), .pop(job_pop), .not_empty(job_valid),
      .pop_data(job_out_data));

   csh_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_data(job_out_data),
      .job_pop(job_pop), .clearing(clearing), .rsp_chan(rsp_chan));
endmodule
